[hw/rtl/sfcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;

    // conversion scales in hundredths; divisor 2^16-1 is handled by shifts
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;

    localparam int TDATA_OUT_W = 96;

    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic        crc_error;
    } frame_t;

    // MSB-first CRC-8 over one byte, unrolled
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/sfcd_frame_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_frame_parse
// Input register, byte position tracking, word assembly and CRC checks.
// ----------------------------------------------------------------------------
module sfcd_frame_parse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tuser,
    output logic            frame_valid,
    input  logic            frame_ready,
    output sfcd_pkg::frame_t frame
);

    localparam logic [2:0] POS_W1_HI  = 3'd0;
    localparam logic [2:0] POS_W1_LO  = 3'd1;
    localparam logic [2:0] POS_W1_CRC = 3'd2;
    localparam logic [2:0] POS_W2_HI  = 3'd3;
    localparam logic [2:0] POS_W2_LO  = 3'd4;
    localparam logic [2:0] POS_W2_CRC = 3'd5;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    logic [2:0]  pos_reg,      pos_next;
    logic [7:0]  crc_reg,      crc_next;
    logic [15:0] word_one_reg, word_one_next;
    logic [7:0]  w2_hi_reg,    w2_hi_next;
    logic [7:0]  w2_lo_reg,    w2_lo_next;
    logic        bad_reg,      bad_next;

    logic [2:0]  pos_eff;
    logic        is_last;
    logic        take;
    logic [7:0]  crc_upd;

    always_comb begin
        pos_eff = (in_start_reg || pos_reg > POS_W2_CRC) ? POS_W1_HI : pos_reg;
    end

    assign is_last     = (pos_eff == POS_W2_CRC);
    assign frame_valid = in_valid_reg && is_last;
    assign take        = in_valid_reg && (!is_last || frame_ready);
    assign s_tready    = !in_valid_reg || take;
    assign crc_upd     = sfcd_pkg::crc8_byte(crc_reg, in_byte_reg);

    assign frame.first_word  = word_one_reg;
    assign frame.second_word = {w2_hi_reg, w2_lo_reg};
    assign frame.crc_error   = bad_reg || (crc_reg != in_byte_reg);

    always_comb begin
        pos_next      = pos_eff + 3'd1;
        crc_next      = crc_reg;
        word_one_next = word_one_reg;
        w2_hi_next    = w2_hi_reg;
        w2_lo_next    = w2_lo_reg;
        bad_next      = bad_reg;
        case (pos_eff)
            POS_W1_HI: begin
                crc_next      = sfcd_pkg::crc8_byte(sfcd_pkg::CRC_INIT, in_byte_reg);
                bad_next      = 1'b0;
                word_one_next = {in_byte_reg, 8'h00};
            end
            POS_W1_LO: begin
                crc_next      = crc_upd;
                word_one_next = {word_one_reg[15:8], in_byte_reg};
            end
            POS_W1_CRC: begin
                bad_next = (crc_reg != in_byte_reg);
                crc_next = sfcd_pkg::CRC_INIT;
            end
            POS_W2_HI: begin
                crc_next   = crc_upd;
                w2_hi_next = in_byte_reg;
            end
            POS_W2_LO: begin
                crc_next   = crc_upd;
                w2_lo_next = in_byte_reg;
            end
            default: begin
                crc_next = sfcd_pkg::CRC_INIT;
                pos_next = POS_W1_HI;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pos_reg      <= POS_W1_HI;
            crc_reg      <= sfcd_pkg::CRC_INIT;
            word_one_reg <= '0;
            w2_hi_reg    <= '0;
            w2_lo_reg    <= '0;
            bad_reg      <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (take) begin
                pos_reg      <= pos_next;
                crc_reg      <= crc_next;
                word_one_reg <= word_one_next;
                w2_hi_reg    <= w2_hi_next;
                w2_lo_reg    <= w2_lo_next;
                bad_reg      <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

endmodule

[hw/rtl/sfcd_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_scale
// Product register, divide by 65535 via shift-add, and result register.
// ----------------------------------------------------------------------------
module sfcd_scale (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            frame_valid,
    output logic            frame_ready,
    input  sfcd_pkg::frame_t frame,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [sfcd_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic            m_tuser
);

    logic        prod_valid_reg;
    logic [15:0] prod_w1_reg;
    logic [15:0] prod_w2_reg;
    logic        prod_err_reg;
    logic [30:0] temp_prod_reg;
    logic [29:0] hum_prod_reg;

    logic        out_valid_reg;
    logic [15:0] out_w1_reg;
    logic [15:0] out_w2_reg;
    logic        out_err_reg;
    logic [14:0] out_temp_reg;
    logic [13:0] out_hum_reg;

    logic        out_en;
    logic [31:0] temp_sum;
    logic [30:0] hum_sum;
    logic [14:0] temp_quot;
    logic [13:0] hum_quot;

    assign out_en      = !out_valid_reg || m_tready;
    assign frame_ready = !prod_valid_reg || out_en;

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x below 2^32 - 1
    assign temp_sum  = {1'b0, temp_prod_reg} + {17'd0, temp_prod_reg[30:16]} + 32'd1;
    assign hum_sum   = {1'b0, hum_prod_reg} + {17'd0, hum_prod_reg[29:16]} + 31'd1;
    assign temp_quot = temp_sum[30:16];
    assign hum_quot  = hum_sum[29:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (frame_ready) begin
                prod_valid_reg <= frame_valid;
            end
            if (out_en) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_ready && frame_valid) begin
            prod_w1_reg   <= frame.first_word;
            prod_w2_reg   <= frame.second_word;
            prod_err_reg  <= frame.crc_error;
            temp_prod_reg <= 31'(frame.first_word * sfcd_pkg::TEMP_SCALE);
            hum_prod_reg  <= 30'(frame.second_word * sfcd_pkg::HUM_SCALE);
        end
        if (out_en && prod_valid_reg) begin
            out_w1_reg   <= prod_w1_reg;
            out_w2_reg   <= prod_w2_reg;
            out_err_reg  <= prod_err_reg;
            // wraps through 15 bits; the true result always fits
            out_temp_reg <= temp_quot - sfcd_pkg::TEMP_OFFSET;
            out_hum_reg  <= hum_quot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_err_reg;
    assign m_tdata  = {3'b000, out_hum_reg, out_temp_reg, out_w1_reg, out_w2_reg,
                       out_w2_reg, out_w1_reg};

endmodule

[hw/rtl/sensor_frame_crc_decode_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_decode_unit
// Six-byte sensor frame decoder: CRC-8 word checks and unit conversion.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless m_tready stalls, with a combinational CRC update.
// Path: the sixth byte's result reaches m_tvalid through the input register,
//   then the product register, then the result register.
// Reset: aresetn clears the byte position, the CRC to 0xFF and all valid flags.
module sensor_frame_crc_decode_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] first_word, [31:16] second_word, [63:32] serial_value,
    // [78:64] temperature_centi, [92:79] humidity_centi, [95:93] zero
    output logic [sfcd_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic        m_tuser    // [0] crc_error
);

    logic             frame_valid;
    logic             frame_ready;
    sfcd_pkg::frame_t frame;

    sfcd_frame_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    sfcd_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

[hw/rtl/sfcd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module sfcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [sfcd_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic        m_tuser
);

    // held transaction keeps valid
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_serial: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[63:48] == m_tdata[15:0]) && (m_tdata[47:32] == m_tdata[31:16]))
        else $error("serial value does not match words");

    // humidity never above 100.00 %
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[92:79] <= 14'd10000) && (m_tdata[95:93] == 3'b000))
        else $error("humidity out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

endmodule

bind sensor_frame_crc_decode_unit sfcd_checker u_sfcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-byte sensor frame decoder. A short table of
// hand-picked frames (all-zero and all-ones words, each check byte wrong,
// resync on a start flag mid-frame, back-to-back frames without a start flag)
// is followed by random frames, most well formed with the odd bad check byte,
// mixed with stray bytes. Every accepted byte goes through a local decoder
// model; each result transaction is checked field by field against it, with
// random stalls on both sides and one long hold-off at the output.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_COUNT   = 1450;
    localparam int QUIET_FROM   = 1250;     // no idling from here on
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 20;       // results seen before the long hold-off
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [31:0] TEMP_MUL  = 32'd17500;
    localparam logic [31:0] HUM_MUL   = 32'd10000;
    localparam logic [31:0] RAW_FULL  = 32'd65535;
    localparam int          TEMP_BASE = -4500;

    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [31:0] serial_value;
        logic        crc_error;
        logic [14:0] temperature_centi;
        logic [13:0] humidity_centi;
    } reading_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;      // want holds a hand-written result
        reading_t   want;
    } stim_row_t;

    localparam reading_t NO_READING = '0;
    localparam reading_t ZERO_GOOD = '{
        first_word: 16'h0000, second_word: 16'h0000, serial_value: 32'h0000_0000,
        crc_error: 1'b0, temperature_centi: -15'sd4500, humidity_centi: 14'd0};
    localparam reading_t ZERO_FIRST_BAD = '{
        first_word: 16'h0000, second_word: 16'h0000, serial_value: 32'h0000_0000,
        crc_error: 1'b1, temperature_centi: -15'sd4500, humidity_centi: 14'd0};
    localparam reading_t FULL_SECOND_BAD = '{
        first_word: 16'hFFFF, second_word: 16'hFFFF, serial_value: 32'hFFFF_FFFF,
        crc_error: 1'b1, temperature_centi: 15'sd13000, humidity_centi: 14'd10000};

    localparam int DIRECTED_LEN = 26;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // zero words, both checks good, straight after reset
        '{8'h00, 1'b1, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
        '{8'h81, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
        '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h81, 1'b0, 1'b1, ZERO_GOOD},
        // all-ones words, no start flag (position wraps), second check wrong
        '{8'hFF, 1'b0, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
        '{8'hAC, 1'b0, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
        '{8'hFF, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b1, FULL_SECOND_BAD},
        // truncated frame, abandoned by the next start flag
        '{8'h12, 1'b1, 1'b0, NO_READING}, '{8'h34, 1'b0, 1'b0, NO_READING},
        // zero words, first check wrong
        '{8'h00, 1'b1, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
        '{8'h7E, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
        '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h81, 1'b0, 1'b1, ZERO_FIRST_BAD},
        // mid-range words, good checks, back to back
        '{8'hBE, 1'b0, 1'b0, NO_READING}, '{8'hEF, 1'b0, 1'b0, NO_READING},
        '{8'h92, 1'b0, 1'b0, NO_READING}, '{8'hBE, 1'b0, 1'b0, NO_READING},
        '{8'hEF, 1'b0, 1'b0, NO_READING}, '{8'h92, 1'b0, 1'b0, NO_READING}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [sfcd_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;

    // decoder model state
    logic [2:0]  frame_pos      = 3'd0;
    logic [7:0]  word_crc       = sfcd_pkg::CRC_INIT;
    logic [15:0] word_one       = '0;
    logic [7:0]  word_two_hi    = '0;
    logic [7:0]  word_two_lo    = '0;
    logic        first_check_bad = 1'b0;

    reading_t pending_readings [$];
    int       mismatch_count = 0;
    int       readings_seen = 0;
    int       bytes_sent = 0;
    int       cycle_count = 0;
    logic     quiet = 1'b0;

    sensor_frame_crc_decode_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // CRC-8, poly 0x31, one data bit at a time from the MSB
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? sfcd_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Advances the model by one byte; returns 1 when a frame completes.
    function automatic logic decode_byte(input logic [7:0] b, input logic start,
                                         output reading_t r);
        logic [2:0]  pos;
        logic [31:0] w1;
        logic [31:0] w2;
        int          t;
        pos = start ? 3'd0 : frame_pos;
        if (pos > 3'd5) begin
            pos = 3'd0;
        end
        r = '0;
        frame_pos = pos + 3'd1;
        case (pos)
            3'd0: begin
                word_crc = crc8_next(sfcd_pkg::CRC_INIT, b);
                first_check_bad = 1'b0;
                word_one = {b, 8'h00};
            end
            3'd1: begin
                word_crc = crc8_next(word_crc, b);
                word_one[7:0] = b;
            end
            3'd2: begin
                first_check_bad = (word_crc != b);
                word_crc = sfcd_pkg::CRC_INIT;
            end
            3'd3: begin
                word_crc = crc8_next(word_crc, b);
                word_two_hi = b;
            end
            3'd4: begin
                word_crc = crc8_next(word_crc, b);
                word_two_lo = b;
            end
            default: begin
                w1 = {16'h0000, word_one};
                w2 = {16'h0000, word_two_hi, word_two_lo};
                t = TEMP_BASE + int'((TEMP_MUL * w1) / RAW_FULL);
                r.first_word = w1[15:0];
                r.second_word = w2[15:0];
                r.serial_value = {w1[15:0], w2[15:0]};
                r.crc_error = first_check_bad || (word_crc != b);
                r.temperature_centi = 15'(t);
                r.humidity_centi = 14'((HUM_MUL * w2) / RAW_FULL);
                word_crc = sfcd_pkg::CRC_INIT;
                frame_pos = 3'd0;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic start,
                             input logic typed, input reading_t want);
        reading_t r;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (decode_byte(b, start, r)) begin
            pending_readings.push_back(typed ? want : r);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(1 << $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // result transactions
    always @(posedge aclk) begin
        reading_t want;
        reading_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.first_word = m_tdata[15:0];
            got.second_word = m_tdata[31:16];
            got.serial_value = m_tdata[63:32];
            got.crc_error = m_tuser;
            got.temperature_centi = m_tdata[78:64];
            got.humidity_centi = m_tdata[92:79];
            readings_seen++;
            if (pending_readings.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (got.first_word !== want.first_word) begin
                    $error("first_word: expected %h, got %h", want.first_word, got.first_word);
                    mismatch_count++;
                end
                if (got.second_word !== want.second_word) begin
                    $error("second_word: expected %h, got %h",
                           want.second_word, got.second_word);
                    mismatch_count++;
                end
                if (got.serial_value !== want.serial_value) begin
                    $error("serial_value: expected %h, got %h",
                           want.serial_value, got.serial_value);
                    mismatch_count++;
                end
                if (got.crc_error !== want.crc_error) begin
                    $error("crc_error: expected %b, got %b", want.crc_error, got.crc_error);
                    mismatch_count++;
                end
                if (got.temperature_centi !== want.temperature_centi) begin
                    $error("temperature_centi: expected %0d, got %0d",
                           $signed(want.temperature_centi), $signed(got.temperature_centi));
                    mismatch_count++;
                end
                if (got.humidity_centi !== want.humidity_centi) begin
                    $error("humidity_centi: expected %0d, got %0d",
                           want.humidity_centi, got.humidity_centi);
                    mismatch_count++;
                end
            end
        end
    end

    // output back-pressure, with one long hold-off so the block fills up
    initial begin
        logic held;
        held = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!held && readings_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sensor_frame_crc_decode_unit verification failed");
        $finish;
    end

    initial begin
        logic [7:0]  frame_bytes [6];
        logic        frame_flags [6];
        logic [15:0] w1;
        logic [15:0] w2;
        int          len;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        while (bytes_sent < ITEM_COUNT) begin
            if ($urandom_range(0, 9) < 8) begin
                // well-formed frame, now and then with a corrupted check byte
                w1 = pick_word();
                w2 = pick_word();
                frame_bytes[0] = w1[15:8];
                frame_bytes[1] = w1[7:0];
                frame_bytes[2] = crc8_next(crc8_next(sfcd_pkg::CRC_INIT, w1[15:8]), w1[7:0]);
                frame_bytes[3] = w2[15:8];
                frame_bytes[4] = w2[7:0];
                frame_bytes[5] = crc8_next(crc8_next(sfcd_pkg::CRC_INIT, w2[15:8]), w2[7:0]);
                case ($urandom_range(0, 9))
                    0: frame_bytes[2] ^= 8'($urandom_range(1, 255));
                    1: frame_bytes[5] ^= 8'($urandom_range(1, 255));
                    default: ;
                endcase
                for (int k = 0; k < 6; k++) begin
                    frame_flags[k] = 1'b0;
                end
                // out of step: usually resync, sometimes leave it broken
                frame_flags[0] = (frame_pos != 3'd0) ? ($urandom_range(0, 4) != 0)
                                                     : 1'($urandom_range(0, 1));
                len = 6;
            end else begin
                // stray bytes with random start flags
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    frame_bytes[k] = 8'($urandom);
                    frame_flags[k] = ($urandom_range(0, 3) == 0);
                end
            end
            for (int k = 0; k < len; k++) begin
                if (bytes_sent >= QUIET_FROM) begin
                    quiet = 1'b1;
                end
                send_byte(frame_bytes[k], frame_flags[k], 1'b0, NO_READING);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("sensor_frame_crc_decode_unit verification clean");
        end else begin
            $display("sensor_frame_crc_decode_unit verification failed");
        end
        $finish;
    end

endmodule
